// ===== rtl/lbqh_pkg.sv =====
// lbqh_pkg: constants, types and helper functions of the log bucket quantile histogram
// used by lbqh_sat_add, lbqh_edge_gen and log_bucket_quantile_histogram
// no dependencies
package lbqh_pkg;

  localparam int MAX_BUCKETS     = 128;
  localparam int IDX_W           = $clog2(MAX_BUCKETS);
  localparam int USED_W          = IDX_W + 1;
  localparam int VAL_W           = 31;
  localparam int CNT_W           = 48;
  localparam int WEIGHT_W        = 32;
  localparam int Q_W             = 16;
  localparam int TGT_W           = 7;
  localparam int LAYER_W         = 4;
  localparam int MIN_LAYERS      = 3;
  localparam int MAX_LAYER_COUNT = 9;

  localparam logic [TGT_W-1:0] TARGET_RESET = 7'd30;
  localparam logic [VAL_W-1:0] VALUE_TOP    = {VAL_W{1'b1}};
  localparam logic [CNT_W-1:0] COUNT_MAX    = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUANT = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    G_IDLE,
    G_ZERO,
    G_ONE,
    G_LAYER
  } gen_state_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_BUILD,
    S_IDLE,
    S_ADD_RD,
    S_ADD_CMP,
    S_ADD_CNT,
    S_ADD_GT,
    S_QT_MUL,
    S_QT_SUM,
    S_QT_RD,
    S_QT_ACC,
    S_FETCH_LO,
    S_FETCH_HI,
    S_FETCH_END,
    S_EMIT
  } state_t;

  // one edge per cycle from the generator
  typedef struct packed {
    logic             vld;
    logic [VAL_W-1:0] value;
    logic             done;
  } edge_gen_t;

  // layers = clamp(target / 10, 3, 9), division by reciprocal 205/2048
  function automatic logic [LAYER_W-1:0] layers_of(input logic [TGT_W-1:0] t);
    logic [14:0]        p;
    logic [LAYER_W-1:0] l;
    p = {8'b0, t} * 15'd205;
    l = p[14:11];
    if (l < LAYER_W'(MIN_LAYERS)) l = LAYER_W'(MIN_LAYERS);
    if (l > LAYER_W'(MAX_LAYER_COUNT)) l = LAYER_W'(MAX_LAYER_COUNT);
    return l;
  endfunction

  // precise = min(max(target, 5*layers) / 5 - layers, layers)
  function automatic logic [LAYER_W-1:0] precise_of(input logic [TGT_W-1:0] t);
    logic [LAYER_W-1:0] l;
    logic [TGT_W-1:0]   t5;
    logic [TGT_W-1:0]   t2;
    logic [14:0]        p;
    logic [4:0]         d;
    l  = layers_of(t);
    t5 = {3'b0, l} * 7'd5;
    t2 = (t < t5) ? t5 : t;
    p  = {8'b0, t2} * 15'd205;
    d  = p[14:10] - {1'b0, l};
    if (d > {1'b0, l}) d = {1'b0, l};
    return d[LAYER_W-1:0];
  endfunction

endpackage

// ===== rtl/log_bucket_quantile_histogram.sv =====
// log_bucket_quantile_histogram: top level, sequencer, edge and count memories
// depends on lbqh_pkg, lbqh_sat_add, lbqh_edge_gen
//
// Log-scale histogram with decade bucket edges, one transaction at a time. After reset and
// after every write of the target register the edges are rebuilt, one per cycle, and all
// counts cleared; in_stall stays high until the rebuild is done. An add runs a binary
// search over the edge memory, each step a read state then a compare state, then a
// read-modify-write of the count and the total through the one shared saturating adder.
// A quantile forms the target product, walks the buckets with a read and an accumulate
// per bucket, then fetches the bounds and loads the result. A bucket read fetches the
// bounds and the count, or goes straight to the result when the index is out of range.
// A result waits in the output register until taken, and the input stays stalled while a
// second result is held behind it.
module log_bucket_quantile_histogram
  import lbqh_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd,
  input  logic [VAL_W-1:0]    sample_value,
  input  logic [WEIGHT_W-1:0] weight,
  input  logic [Q_W-1:0]      q_frac,
  input  logic [IDX_W-1:0]    bucket_select,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [IDX_W-1:0]    bucket_index,
  output logic [VAL_W-1:0]    low_bound,
  output logic [VAL_W-1:0]    high_bound,
  output logic [VAL_W-1:0]    estimate,
  output logic [CNT_W-1:0]    bucket_total,
  output logic                not_found
);

  state_t state, state_next;

  logic [TGT_W-1:0]    target_cfg;
  logic [USED_W-1:0]   used;
  logic [CNT_W-1:0]    grand_total;
  logic                cfg_wr;
  logic                in_acc;
  logic                gen_start;
  edge_gen_t           gen;

  // memories
  logic [VAL_W-1:0]    edge_mem [MAX_BUCKETS];
  logic [CNT_W-1:0]    cnt_mem  [MAX_BUCKETS];
  logic [MAX_BUCKETS-1:0] cnt_valid;
  logic [IDX_W-1:0]    edge_raddr, cnt_raddr;
  logic [VAL_W-1:0]    edge_rd;
  logic [CNT_W-1:0]    cnt_rd_raw;
  logic                cnt_rd_vld;
  logic [CNT_W-1:0]    cnt_rd;
  logic                cnt_we;

  // transaction registers
  logic [VAL_W-1:0]    val;
  logic [WEIGHT_W-1:0] wgt;
  logic [Q_W-1:0]      q;
  logic [IDX_W-1:0]    lo, hi, mid;
  logic [USED_W-1:0]   mid_sum;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    idx_inc;
  logic                idx_last;
  logic                miss;
  logic [USED_W-1:0]   walk;
  logic [CNT_W-1:0]    run_sum, q_target;
  logic [CNT_W-1:0]    prod_hi;
  logic [31:0]         prod_lo;
  logic [VAL_W-1:0]    lo_b, hi_b;
  logic [CNT_W-1:0]    cnt_b;
  logic [VAL_W:0]      mid_b;

  // shared adder
  logic [CNT_W-1:0]    add_a, add_b, add_sum;

  lbqh_sat_add u_add (
    .a   (add_a),
    .b   (add_b),
    .sum (add_sum)
  );

  lbqh_edge_gen u_gen (
    .clk    (clk),
    .rst    (rst),
    .start  (gen_start),
    .target (target_cfg),
    .gen    (gen)
  );

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {25'b0, target_cfg} : '0;

  // a register write takes the idle slot, so no transaction is taken with it
  assign in_stall = (state != S_IDLE) || cfg_wr;
  assign in_acc   = in_valid && !in_stall;

  assign mid_sum  = {1'b0, lo} + {1'b0, hi} + USED_W'(1);
  assign mid      = mid_sum[USED_W-1:1];
  assign idx_inc  = idx + IDX_W'(1);
  assign idx_last = ({1'b0, idx} + USED_W'(1) >= used);
  assign cnt_rd   = cnt_rd_vld ? cnt_rd_raw : '0;
  assign mid_b    = {1'b0, lo_b} + {1'b0, hi_b};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT:  state_next = S_BUILD;
      S_BUILD: if (gen.done) state_next = S_IDLE;
      S_IDLE: begin
        if (cfg_wr) begin
          state_next = S_INIT;
        end else if (in_acc) begin
          case (cmd)
            CMD_ADD:   state_next = S_ADD_RD;
            CMD_QUANT: state_next = S_QT_MUL;
            CMD_READ:  state_next = ({1'b0, bucket_select} < used) ? S_FETCH_LO : S_EMIT;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_ADD_RD:    state_next = (lo < hi) ? S_ADD_CMP : S_ADD_CNT;
      S_ADD_CMP:   state_next = S_ADD_RD;
      S_ADD_CNT:   state_next = S_ADD_GT;
      S_ADD_GT:    state_next = S_IDLE;
      S_QT_MUL:    state_next = S_QT_SUM;
      S_QT_SUM:    state_next = S_QT_RD;
      S_QT_RD:     state_next = (walk < used) ? S_QT_ACC : S_EMIT;
      S_QT_ACC:    state_next = (add_sum > q_target) ? S_FETCH_LO : S_QT_RD;
      S_FETCH_LO:  state_next = S_FETCH_HI;
      S_FETCH_HI:  state_next = S_FETCH_END;
      S_FETCH_END: state_next = S_EMIT;
      S_EMIT:      if (!out_valid || !out_stall) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // memory addresses and adder operands
  always_comb begin
    gen_start  = 1'b0;
    edge_raddr = mid;
    cnt_raddr  = lo;
    cnt_we     = 1'b0;
    add_a      = cnt_rd;
    add_b      = {{(CNT_W-WEIGHT_W){1'b0}}, wgt};
    case (state)
      S_INIT:     gen_start = 1'b1;
      S_ADD_RD:   edge_raddr = mid;
      S_ADD_CNT:  cnt_we = 1'b1;
      S_ADD_GT:   add_a = grand_total;
      S_QT_RD:    cnt_raddr = walk[IDX_W-1:0];
      S_QT_ACC: begin
        add_a = run_sum;
        add_b = cnt_rd;
      end
      S_FETCH_LO: begin
        edge_raddr = idx;
        cnt_raddr  = idx;
      end
      S_FETCH_HI: edge_raddr = idx_inc;
      default:    gen_start = 1'b0;
    endcase
  end

  // edge memory
  always_ff @(posedge clk) begin
    if (state == S_BUILD && gen.vld && used < USED_W'(MAX_BUCKETS)) begin
      edge_mem[used[IDX_W-1:0]] <= gen.value;
    end
    edge_rd <= edge_mem[edge_raddr];
  end

  // count memory
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[lo] <= add_sum;
    end
    cnt_rd_raw <= cnt_mem[cnt_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      target_cfg    <= TARGET_RESET;
      used          <= '0;
      grand_total   <= '0;
      cnt_valid     <= '0;
      cnt_rd_vld    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state      <= state_next;
      cnt_rd_vld <= cnt_valid[cnt_raddr];
      if (state == S_IDLE && cfg_wr) begin
        target_cfg <= pwdata[TGT_W-1:0];
      end
      if (state == S_INIT) begin
        used        <= '0;
        grand_total <= '0;
        cnt_valid   <= '0;
      end else if (state == S_BUILD && gen.vld && used < USED_W'(MAX_BUCKETS)) begin
        used <= used + USED_W'(1);
      end
      if (cnt_we) begin
        cnt_valid[lo] <= 1'b1;
      end
      if (state == S_ADD_GT) begin
        grand_total <= add_sum;
      end
      // load a new result, or drop the one just taken
      if (state == S_EMIT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        val  <= sample_value;
        wgt  <= weight;
        q    <= q_frac;
        lo   <= '0;
        hi   <= used[IDX_W-1:0] - IDX_W'(1);
        idx  <= bucket_select;
        miss <= ({1'b0, bucket_select} >= used);
      end
      S_ADD_CMP: begin
        if (edge_rd <= val) lo <= mid;
        else hi <= mid - IDX_W'(1);
      end
      S_QT_MUL: begin
        prod_hi <= q * grand_total[CNT_W-1:16];
        prod_lo <= q * grand_total[15:0];
      end
      S_QT_SUM: begin
        q_target <= prod_hi + {{(CNT_W-16){1'b0}}, prod_lo[31:16]};
        walk     <= '0;
        run_sum  <= '0;
        miss     <= 1'b1;
        idx      <= '0;
      end
      S_QT_ACC: begin
        run_sum <= add_sum;
        walk    <= walk + USED_W'(1);
        if (add_sum > q_target) begin
          idx  <= walk[IDX_W-1:0];
          miss <= 1'b0;
        end
      end
      S_FETCH_HI: begin
        lo_b  <= edge_rd;
        cnt_b <= cnt_rd;
      end
      S_FETCH_END: begin
        hi_b <= idx_last ? VALUE_TOP : edge_rd - VAL_W'(1);
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          bucket_index <= idx;
          not_found    <= miss;
          low_bound    <= miss ? '0 : lo_b;
          high_bound   <= miss ? '0 : hi_b;
          estimate     <= miss ? '0 : mid_b[VAL_W:1];
          bucket_total <= miss ? '0 : cnt_b;
        end
      end
      default: begin
        val <= val;
      end
    endcase
  end

  // checks
  a_nf_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && not_found |-> low_bound == '0 && high_bound == '0 && bucket_total == '0)
    else $error("not found result carries data");

  a_est_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !not_found |-> estimate >= low_bound && estimate <= high_bound)
    else $error("estimate outside bucket bounds");

  a_used_ok: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> used != '0 && used <= USED_W'(MAX_BUCKETS))
    else $error("bucket count out of range");

  a_search: assert property (@(posedge clk) disable iff (rst)
    state == S_ADD_CMP |-> lo < hi && {1'b0, hi} < used)
    else $error("binary search bounds crossed");

endmodule

// ===== rtl/lbqh_sat_add.sv =====
// lbqh_sat_add: the shared saturating count adder
// depends on lbqh_pkg
module lbqh_sat_add
  import lbqh_pkg::*;
(
  input  logic [CNT_W-1:0] a,
  input  logic [CNT_W-1:0] b,
  output logic [CNT_W-1:0] sum
);

  logic [CNT_W:0] raw;

  // add with carry out, clamp on overflow
  assign raw = {1'b0, a} + {1'b0, b};
  assign sum = raw[CNT_W] ? COUNT_MAX : raw[CNT_W-1:0];

endmodule

// ===== rtl/lbqh_edge_gen.sv =====
// lbqh_edge_gen: steps out the decade bucket edges, one per cycle, after start
// depends on lbqh_pkg
module lbqh_edge_gen
  import lbqh_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [TGT_W-1:0] target,
  output edge_gen_t        gen
);

  gen_state_t         phase, phase_next;
  logic [LAYER_W-1:0] layer, layers, precise, k;
  logic [VAL_W-1:0]   scale, cur;
  logic [LAYER_W-1:0] step, k_adv;
  logic               last_k, last_layer;
  logic [VAL_W-1:0]   scale10;

  // step 1 in precise layers, 2 in coarse ones
  assign step       = (layer < precise) ? LAYER_W'(1) : LAYER_W'(2);
  assign k_adv      = k + step;
  assign last_k     = (k_adv > LAYER_W'(10));
  assign last_layer = (layer == layers - LAYER_W'(1));
  assign scale10    = (scale << 3) + (scale << 1);

  // next state
  always_comb begin
    phase_next = phase;
    case (phase)
      G_IDLE:  if (start) phase_next = G_ZERO;
      G_ZERO:  phase_next = (precise != '0) ? G_ONE : G_LAYER;
      G_ONE:   phase_next = G_LAYER;
      G_LAYER: if (last_k && last_layer) phase_next = G_IDLE;
      default: phase_next = G_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    gen.vld   = 1'b0;
    gen.value = cur;
    gen.done  = 1'b0;
    case (phase)
      G_IDLE:  gen.vld = 1'b0;
      G_ZERO: begin
        gen.vld   = 1'b1;
        gen.value = '0;
      end
      G_ONE: begin
        gen.vld   = 1'b1;
        gen.value = VAL_W'(1);
      end
      G_LAYER: begin
        gen.vld  = 1'b1;
        gen.done = last_k && last_layer;
      end
      default: gen.vld = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= G_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // layer walk registers
  always_ff @(posedge clk) begin
    if (start) begin
      layers  <= layers_of(target);
      precise <= precise_of(target);
      layer   <= '0;
      scale   <= VAL_W'(1);
      cur     <= VAL_W'(2);
      k       <= LAYER_W'(2);
    end else if (phase == G_LAYER) begin
      if (!last_k) begin
        k   <= k_adv;
        cur <= cur + ((step == LAYER_W'(1)) ? scale : (scale << 1));
      end else begin
        layer <= layer + LAYER_W'(1);
        scale <= scale10;
        cur   <= scale10 << 1;
        k     <= LAYER_W'(2);
      end
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for log_bucket_quantile_histogram
// depends on lbqh_pkg and the log_bucket_quantile_histogram rtl
// queue-fed driver, clocked monitor, in-house histogram predictor, apb writes of the target
module tb;
  import lbqh_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 60;

  typedef struct packed {
    cmd_t             op;
    logic [VAL_W-1:0] value;
    logic [31:0]      wt;
    logic [15:0]      q;
    logic [6:0]       sel;
  } sample_cmd_t;

  typedef struct packed {
    logic [6:0]       idx;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic [VAL_W-1:0] est;
    logic [CNT_W-1:0] cnt;
    logic             miss;
  } bucket_report_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall;
  logic [1:0] cmd;
  logic [VAL_W-1:0] sample_value;
  logic [31:0] weight;
  logic [15:0] q_frac;
  logic [6:0] bucket_select;
  logic out_valid, out_stall;
  logic [6:0] bucket_index;
  logic [VAL_W-1:0] low_bound, high_bound, estimate;
  logic [CNT_W-1:0] bucket_total;
  logic not_found;

  log_bucket_quantile_histogram dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .sample_value(sample_value),
    .weight(weight), .q_frac(q_frac), .bucket_select(bucket_select),
    .out_valid(out_valid), .out_stall(out_stall), .bucket_index(bucket_index),
    .low_bound(low_bound), .high_bound(high_bound), .estimate(estimate),
    .bucket_total(bucket_total), .not_found(not_found)
  );

  // histogram mirror
  logic [CNT_W-1:0] hist_count [MAX_BUCKETS];
  logic [CNT_W-1:0] hist_sum;
  logic [VAL_W-1:0] hist_edge [MAX_BUCKETS];
  int unsigned      hist_used;

  sample_cmd_t    pending_cmds [$];
  bucket_report_t expected_reports [$];
  sample_cmd_t    cur_cmd;
  logic in_taken;
  logic quiet;
  int in_gap, out_gap, mismatches, idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // append to the pending and expected queues
  task automatic queue_cmd(input sample_cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic expect_report(input bucket_report_t r);
    expected_reports.insert(expected_reports.size(), r);
  endtask

  function automatic logic [CNT_W-1:0] sat_sum(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[CNT_W]) return COUNT_MAX;
    return s[CNT_W-1:0];
  endfunction

  // rebuild the decade edges and clear all counts
  task automatic rebuild_edges(input logic [6:0] tgt);
    int unsigned layers, t, precise, step, scale;
    layers = tgt / 10;
    if (layers < 3) layers = 3;
    if (layers > MAX_LAYER_COUNT) layers = MAX_LAYER_COUNT;
    t = (tgt < 5 * layers) ? 5 * layers : tgt;
    precise = t / 5 - layers;
    if (precise > layers) precise = layers;
    hist_used = 0;
    hist_sum = '0;
    scale = 1;
    for (int i = 0; i < MAX_BUCKETS; i++) begin
      hist_count[i] = '0;
      hist_edge[i] = '0;
    end
    hist_edge[hist_used] = '0;
    hist_used++;
    if (precise > 0) begin
      hist_edge[hist_used] = VAL_W'(1);
      hist_used++;
    end
    for (int l = 0; l < layers; l++) begin
      step = (l < precise) ? 1 : 2;
      for (int k = 2; k <= 10; k += step)
        if (hist_used < MAX_BUCKETS) begin
          hist_edge[hist_used] = VAL_W'(k * scale);
          hist_used++;
        end
      scale = scale * 10;
    end
  endtask

  function automatic bucket_report_t report_of(input int unsigned i, input logic found);
    bucket_report_t r;
    logic [31:0] top;
    logic [31:0] both;
    r = '0;
    r.idx = i[6:0];
    if (!found) begin
      r.miss = 1'b1;
      return r;
    end
    top = (i + 1 >= hist_used) ? {1'b0, VALUE_TOP} : {1'b0, hist_edge[i + 1]} - 32'd1;
    both = {1'b0, hist_edge[i]} + {1'b0, top[30:0]};
    r.lo = hist_edge[i];
    r.hi = top[VAL_W-1:0];
    r.est = both[31:1];
    r.cnt = hist_count[i];
    return r;
  endfunction

  // apply one accepted transaction to the mirror, queue any report it yields
  task automatic apply_cmd(input sample_cmd_t c);
    int unsigned lo, hi, mid;
    logic [CNT_W-1:0] quota, run;
    logic [31:0] part_lo;
    logic found;
    case (c.op)
      CMD_ADD: begin
        lo = 0;
        hi = hist_used - 1;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          if (hist_edge[mid] <= c.value) lo = mid;
          else hi = mid - 1;
        end
        hist_sum = sat_sum(hist_sum, {{(CNT_W-32){1'b0}}, c.wt});
        hist_count[lo] = sat_sum(hist_count[lo], {{(CNT_W-32){1'b0}}, c.wt});
      end
      CMD_QUANT: begin
        part_lo = {16'b0, c.q} * {16'b0, hist_sum[15:0]};
        quota = {32'b0, c.q} * {16'b0, hist_sum[CNT_W-1:16]} + {32'b0, part_lo[31:16]};
        run = '0;
        found = 1'b0;
        for (int i = 0; i < hist_used && !found; i++) begin
          run = sat_sum(run, hist_count[i]);
          if (run > quota) begin
            found = 1'b1;
            expect_report(report_of(i, 1'b1));
          end
        end
        if (!found) expect_report(report_of(0, 1'b0));
      end
      CMD_READ: begin
        if (32'(c.sel) < hist_used) expect_report(report_of(32'(c.sel), 1'b1));
        else expect_report(report_of(32'(c.sel), 1'b0));
      end
      default: ;
    endcase
  endtask

  // input driver: holds a stalled transaction, otherwise pops or idles
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0 && !quiet && $urandom_range(0, 15) == 0) begin
        in_gap <= $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cur_cmd = pending_cmds.pop_front();
        in_valid <= 1'b1;
        cmd <= cur_cmd.op;
        sample_value <= cur_cmd.value;
        weight <= cur_cmd.wt;
        q_frac <= cur_cmd.q;
        bucket_select <= cur_cmd.sel;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall bursts
  always @(negedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= (out_gap > 1);
    end else if ($urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(1, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: predict on input accept, compare on output accept, watchdog
  always @(posedge clk) begin
    bucket_report_t want, got;
    in_taken <= in_valid && !in_stall && !rst;
    if (!rst) begin
      if (in_valid && !in_stall) apply_cmd(cur_cmd);
      if (out_valid && !out_stall) begin
        got = '{bucket_index, low_bound, high_bound, estimate, bucket_total, not_found};
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned b;
    b = $urandom_range(0, hist_used - 1);
    case ($urandom_range(0, 3))
      0: return hist_edge[b];
      1: return (hist_edge[b] == 0) ? VAL_W'(0) : hist_edge[b] - VAL_W'(1);
      2: return VAL_W'($urandom & ((32'h1 << $urandom_range(0, 31)) - 1));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic sample_cmd_t make_cmd(input cmd_t op, input logic [VAL_W-1:0] v,
                                           input logic [31:0] w, input logic [15:0] q,
                                           input logic [6:0] s);
    sample_cmd_t c;
    c.op = op; c.value = v; c.wt = w; c.q = q; c.sel = s;
    return c;
  endfunction

  function automatic sample_cmd_t random_cmd();
    int unsigned r;
    logic [31:0] w;
    r = $urandom_range(0, 99);
    w = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 1000);
    if (r < 50) return make_cmd(CMD_ADD, pick_value(), w, 16'($urandom), 7'($urandom));
    if (r < 75) return make_cmd(CMD_QUANT, VAL_W'($urandom), $urandom, 16'($urandom),
                                7'($urandom));
    if (r < 95) return make_cmd(CMD_READ, VAL_W'($urandom), $urandom, 16'($urandom),
                                ($urandom_range(0, 3) == 0) ? 7'($urandom) :
                                7'($urandom_range(0, hist_used - 1)));
    return make_cmd(CMD_NONE, VAL_W'($urandom), $urandom, 16'($urandom), 7'($urandom));
  endfunction

  // wait for every queued transaction and report, then let the block settle
  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_target(input logic [6:0] tgt);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = 3'd0; pwdata = {25'b0, tgt};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    rebuild_edges(tgt);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  initial begin
    logic [6:0] settings [6];
    settings = '{7'd0, 7'd99, 7'd127, 7'd7, 7'd55, 7'd20};
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; out_stall = 1'b0; cmd = CMD_NONE;
    sample_value = '0; weight = '0; q_frac = '0; bucket_select = '0;
    in_gap = 0; out_gap = 0; mismatches = 0; idle_cycles = 0; quiet = 1'b0;
    cur_cmd = '0;
    rebuild_edges(TARGET_RESET);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty histogram, range ends, zero weight, unused command
    queue_cmd(make_cmd(CMD_QUANT, 0, 0, 16'hFFFF, 0));
    queue_cmd(make_cmd(CMD_READ, 0, 0, 0, 7'd127));
    queue_cmd(make_cmd(CMD_READ, 0, 0, 0, 7'(hist_used)));
    queue_cmd(make_cmd(CMD_READ, 0, 0, 0, 7'(hist_used - 1)));
    queue_cmd(make_cmd(CMD_ADD, 5, 0, 0, 0));
    queue_cmd(make_cmd(CMD_QUANT, 0, 0, 0, 0));
    queue_cmd(make_cmd(CMD_ADD, 0, 1, 0, 0));
    queue_cmd(make_cmd(CMD_ADD, 1, 3, 0, 0));
    queue_cmd(make_cmd(CMD_ADD, VALUE_TOP, 32'hFFFF_FFFF, 0, 0));
    queue_cmd(make_cmd(CMD_ADD, 999, 7, 0, 0));
    queue_cmd(make_cmd(CMD_ADD, 1000, 9, 0, 0));
    queue_cmd(make_cmd(CMD_NONE, 7, 7, 7, 7));
    queue_cmd(make_cmd(CMD_QUANT, 0, 0, 0, 0));
    queue_cmd(make_cmd(CMD_QUANT, 0, 0, 16'h8000, 0));
    queue_cmd(make_cmd(CMD_QUANT, 0, 0, 16'hFFFF, 0));
    for (int i = 0; i < 4; i++)
      queue_cmd(make_cmd(CMD_READ, 0, 0, 0, 7'(i)));
    queue_cmd(make_cmd(CMD_READ, 0, 0, 0, 7'(hist_used - 1)));
    for (int i = 0; i < 250; i++) queue_cmd(random_cmd());
    drain();

    // random phases across target settings
    foreach (settings[p]) begin
      write_target(settings[p]);
      for (int i = 0; i < 190; i++) queue_cmd(random_cmd());
      drain();
    end

    // heavy weights on two buckets, no idling from here on
    quiet = 1'b1;
    write_target(7'd0);
    for (int i = 0; i < 60; i++)
      queue_cmd(make_cmd(CMD_ADD, (i % 2) ? 31'd3 : 31'd50, 32'hFFFF_FFFF, 0, 0));
    queue_cmd(make_cmd(CMD_READ, 0, 0, 0, 7'd1));
    queue_cmd(make_cmd(CMD_READ, 0, 0, 0, 7'd3));
    queue_cmd(make_cmd(CMD_QUANT, 0, 0, 16'hFFFF, 0));
    queue_cmd(make_cmd(CMD_QUANT, 0, 0, 16'h0000, 0));
    queue_cmd(make_cmd(CMD_ADD, 10, 32'hFFFF_FFFF, 0, 0));
    queue_cmd(make_cmd(CMD_QUANT, 0, 0, 16'h7FFF, 0));
    for (int i = 0; i < 40; i++) queue_cmd(random_cmd());
    drain();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
